@@ sv/wtn_pkg.sv @@
// Package for the word token normalizer: shared types, character codes and
// byte classification helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wtn_pkg;

	localparam int PENDING_DEPTH_DEF = 32;
	localparam int QUEUE_DEPTH       = 4;

	// character codes
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;

	// one classified byte, handed from front to back
	typedef struct packed {
		logic       mark;   // store ch in the mark store
		logic       alnum;  // flush held marks, then emit ch
		logic       term;   // emit terminator afterwards
		logic [7:0] ch;
		logic       se;
		logic       ds;
		logic       we;
		logic       po;
	} wtn_cmd_t;

	// one result item
	typedef struct packed {
		logic [7:0] ch;
		logic       term;
		logic       se;
		logic       ds;
		logic       we;
		logic       po;
		logic       last;
	} wtn_res_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_stop(input logic [7:0] c);
		return (c == CH_PERIOD) || (c == CH_BANG) || (c == CH_QMARK) ||
		       (c == CH_COLON);
	endfunction

endpackage

`default_nettype wire

@@ sv/wtn_tok_if.sv @@
// Input channel: raw token bytes with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface wtn_tok_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_in_token;

	modport source (output valid, output char_code, output last_in_token, input ready);
	modport sink   (input valid, input char_code, input last_in_token, output ready);
endinterface

`default_nettype wire

@@ sv/wtn_word_if.sv @@
// Output channel: cleaned word bytes and terminator flags, valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface wtn_word_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       is_terminator;
	logic       sentence_end;
	logic       dialogue_start;
	logic       word_empty;
	logic       pending_overflow;
	logic       last_result;

	modport source (output valid, output out_char, output is_terminator,
		output sentence_end, output dialogue_start, output word_empty,
		output pending_overflow, output last_result, input ready);
	modport sink   (input valid, input out_char, input is_terminator,
		input sentence_end, input dialogue_start, input word_empty,
		input pending_overflow, input last_result, output ready);
endinterface

`default_nettype wire

@@ sv/word_token_normalizer_core.sv @@
// Word token normalizer top level. A plain byte's result is registered in the command
// queue and then in the output register. Throughput: one byte per cycle, set by the
// front end, while the queue is not full; a letter or digit that ends a token takes a
// further back-end step for the terminator. A flush of held marks occupies the back end
// with one registered read of the mark store per mark; intake stalls once the 4-entry
// queue fills. Reset clears all control and token state; the mark store is not cleared.
// Depends on wtn_pkg, wtn_tok_if, wtn_word_if, wtn_front, wtn_fifo, wtn_back.
`timescale 1ns / 1ps
`default_nettype none

module word_token_normalizer_core #(
	parameter int PENDING_DEPTH = wtn_pkg::PENDING_DEPTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	wtn_tok_if.sink      tok,
	wtn_word_if.source   word
);
	import wtn_pkg::*;

	localparam int CW = $clog2(PENDING_DEPTH + 1);
	localparam int QW = $bits(wtn_cmd_t) + CW;

	logic          push;
	wtn_cmd_t      f_cmd;
	logic [CW-1:0] f_cnt;
	logic          q_full;
	logic          q_valid;
	logic          pop;
	logic [QW-1:0] q_rdata;
	wtn_cmd_t      b_cmd;
	logic [CW-1:0] b_cnt;

	assign b_cmd = q_rdata[QW-1:CW];
	assign b_cnt = q_rdata[CW-1:0];

	wtn_front #(
		.PENDING_DEPTH (PENDING_DEPTH),
		.CW            (CW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok),
		.q_full (q_full),
		.push   (push),
		.cmd    (f_cmd),
		.cnt    (f_cnt)
	);

	wtn_fifo #(
		.W (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     ({f_cmd, f_cnt}),
		.pop       (pop),
		.rdata     (q_rdata),
		.full      (q_full),
		.not_empty (q_valid)
	);

	wtn_back #(
		.PENDING_DEPTH (PENDING_DEPTH),
		.CW            (CW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (b_cmd),
		.q_cnt   (b_cnt),
		.pop     (pop),
		.word    (word)
	);

endmodule

`default_nettype wire

@@ sv/wtn_front.sv @@
// Front end: accepts token bytes, tracks per-token state and classifies each
// byte into a command for the back end. Depends on wtn_pkg, wtn_tok_if.
`timescale 1ns / 1ps
`default_nettype none

module wtn_front #(
	parameter int PENDING_DEPTH = wtn_pkg::PENDING_DEPTH_DEF,
	parameter int CW            = $clog2(PENDING_DEPTH + 1)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	wtn_tok_if.sink               tok,
	input  wire                   q_full,
	output logic                  push,
	output wtn_pkg::wtn_cmd_t     cmd,
	output logic [CW-1:0]         cnt
);
	import wtn_pkg::*;

	logic          seen_q;
	logic [CW-1:0] held_q;
	logic          se_q;
	logic          start_q;
	logic          dash_q;
	logic          ovf_q;

	logic       accept;
	logic [7:0] c;
	logic       alnum;
	logic       mark_c;
	logic       full;
	logic       do_mark;
	logic       ovf_now;
	logic       se_now;
	logic       ds_now;

	assign tok.ready = !q_full;
	assign accept    = tok.valid && tok.ready;

	// classify the byte against the current token state
	always_comb begin
		c       = tok.char_code;
		alnum   = is_alnum(c);
		mark_c  = (c == CH_APOS) || (c == CH_HYPHEN);
		full    = (held_q == CW'(PENDING_DEPTH));
		do_mark = !alnum && mark_c && seen_q && !full;
		ovf_now = !alnum && mark_c && seen_q && full;
		se_now  = (c != CH_DQUOTE) ? is_stop(c) : se_q;
		ds_now  = start_q ? (c == CH_HYPHEN) : dash_q;

		// a mark on the final byte is trailing: only the terminator goes out
		cmd.mark  = do_mark && !tok.last_in_token;
		cmd.alnum = alnum;
		cmd.term  = tok.last_in_token;
		cmd.ch    = alnum ? to_lower(c) : c;
		cmd.se    = se_now;
		cmd.ds    = ds_now;
		cmd.we    = !(seen_q || alnum);
		cmd.po    = ovf_q || ovf_now;
		// write index for a mark, flush length for a letter or digit
		cnt       = held_q;
		push      = accept && (do_mark || alnum || tok.last_in_token);
	end

	// per-token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			held_q  <= '0;
			se_q    <= 1'b0;
			start_q <= 1'b1;
			dash_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (tok.last_in_token) begin
				seen_q  <= 1'b0;
				held_q  <= '0;
				se_q    <= 1'b0;
				start_q <= 1'b1;
				dash_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				start_q <= 1'b0;
				dash_q  <= ds_now;
				se_q    <= se_now;
				if (alnum) begin
					seen_q <= 1'b1;
					held_q <= '0;
				end else if (do_mark) begin
					held_q <= held_q + 1'b1;
				end
				if (ovf_now) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/wtn_fifo.sv @@
// Short command queue between front and back end, register based.
// Depends on wtn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtn_fifo #(
	parameter int W = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire  [W-1:0] wdata,
	input  wire          pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         not_empty
);
	import wtn_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] num_q;

	assign full      = (num_q == NW'(QUEUE_DEPTH));
	assign not_empty = (num_q != '0);
	assign rdata     = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			num_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				num_q <= num_q + 1'b1;
			end else if (pop && !push) begin
				num_q <= num_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/wtn_back.sv @@
// Back end: executes commands, owns the mark store, flushes held marks and
// drives the registered output channel. Depends on wtn_pkg, wtn_word_if.
`timescale 1ns / 1ps
`default_nettype none

module wtn_back #(
	parameter int PENDING_DEPTH = wtn_pkg::PENDING_DEPTH_DEF,
	parameter int CW            = $clog2(PENDING_DEPTH + 1)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   q_valid,
	input  wire wtn_pkg::wtn_cmd_t q_cmd,
	input  wire  [CW-1:0]         q_cnt,
	output logic                  pop,
	wtn_word_if.source            word
);
	import wtn_pkg::*;

	localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MARK = 3'd2;
	localparam logic [2:0] ST_CHAR = 3'd3;
	localparam logic [2:0] ST_TERM = 3'd4;

	logic [7:0]    mem [PENDING_DEPTH];
	logic [7:0]    rd_data_q;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	wtn_cmd_t      cmd_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_d;
	logic          latch;

	wtn_res_t      out_q;
	wtn_res_t      res;
	logic          out_valid_q;
	logic          out_free;
	logic          load;
	logic          mem_we;

	assign out_free = !out_valid_q || word.ready;

	// mark store: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_cnt[IW-1:0]] <= q_cmd.ch;
		end
		rd_data_q <= mem[idx_q[IW-1:0]];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		pop     = 1'b0;
		latch   = 1'b0;
		load    = 1'b0;
		mem_we  = 1'b0;
		res     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_cmd.mark) begin
						pop    = 1'b1;
						mem_we = 1'b1;
					end else if (q_cmd.alnum && q_cnt != '0) begin
						pop     = 1'b1;
						latch   = 1'b1;
						idx_d   = '0;
						state_d = ST_RD;
					end else if (out_free) begin
						pop  = 1'b1;
						load = 1'b1;
						if (q_cmd.alnum) begin
							res.ch   = q_cmd.ch;
							res.last = !q_cmd.term;
							if (q_cmd.term) begin
								latch   = 1'b1;
								state_d = ST_TERM;
							end
						end else begin
							res.term = 1'b1;
							res.se   = q_cmd.se;
							res.ds   = q_cmd.ds;
							res.we   = q_cmd.we;
							res.po   = q_cmd.po;
							res.last = 1'b1;
						end
					end
				end
			end
			ST_RD: begin
				state_d = ST_MARK;
			end
			ST_MARK: begin
				if (out_free) begin
					load   = 1'b1;
					res.ch = rd_data_q;
					if (idx_q + 1'b1 < cnt_q) begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_RD;
					end else begin
						state_d = ST_CHAR;
					end
				end
			end
			ST_CHAR: begin
				if (out_free) begin
					load     = 1'b1;
					res.ch   = cmd_q.ch;
					res.last = !cmd_q.term;
					state_d  = cmd_q.term ? ST_TERM : ST_IDLE;
				end
			end
			ST_TERM: begin
				if (out_free) begin
					load     = 1'b1;
					res.term = 1'b1;
					res.se   = cmd_q.se;
					res.ds   = cmd_q.ds;
					res.we   = cmd_q.we;
					res.po   = cmd_q.po;
					res.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (word.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (latch) begin
			cmd_q <= q_cmd;
			cnt_q <= q_cnt;
		end
		if (load) begin
			out_q <= res;
		end
	end

	assign word.valid            = out_valid_q;
	assign word.out_char         = out_q.ch;
	assign word.is_terminator    = out_q.term;
	assign word.sentence_end     = out_q.se;
	assign word.dialogue_start   = out_q.ds;
	assign word.word_empty       = out_q.we;
	assign word.pending_overflow = out_q.po;
	assign word.last_result      = out_q.last;

endmodule

`default_nettype wire

@@ tb/word_token_normalizer_core_tb.sv @@
// Testbench for word_token_normalizer_core: drives raw token bytes, predicts
// the cleaned word and terminator flags, and checks every output transfer.
// Depends on wtn_pkg, wtn_tok_if, wtn_word_if and the core RTL.
`timescale 1ns / 1ps

module word_token_normalizer_core_tb;
	import wtn_pkg::*;

	localparam int STORE_DEPTH  = PENDING_DEPTH_DEF;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;

	// character ranges used by the predictor and the generators
	localparam logic [7:0] CH_DIGIT_0  = 8'h30;
	localparam logic [7:0] CH_DIGIT_9  = 8'h39;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	typedef logic [7:0] byte_q_t[$];

	logic clk = 1'b0;
	logic arst_n;

	wtn_tok_if  tok ();
	wtn_word_if word ();

	word_token_normalizer_core #(
		.PENDING_DEPTH(STORE_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok),
		.word   (word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_left    = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int mismatch_count = 0;

	wtn_res_t word_expect_q[$];

	// predictor state for the token in progress
	logic       word_seen  = 1'b0;
	logic [7:0] held_q[$];
	logic [7:0] last_plain = 8'h00;
	logic       have_plain = 1'b0;
	logic       token_open = 1'b1;
	logic       lead_dash  = 1'b0;
	logic       marks_lost = 1'b0;

	function automatic logic is_word_char(input logic [7:0] c);
		return (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
		       (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
		       (c >= CH_LOWER_A && c <= CH_LOWER_Z);
	endfunction

	function automatic void push_word_result(input logic [7:0] ch, input logic term,
			input logic se, input logic ds, input logic we, input logic po);
		wtn_res_t r;
		r.ch   = ch;
		r.term = term;
		r.se   = se;
		r.ds   = ds;
		r.we   = we;
		r.po   = po;
		r.last = 1'b0;
		word_expect_q.push_back(r);
	endfunction

	// works out the results of one accepted byte
	function automatic void predict_clean_byte(input logic [7:0] c, input logic fin);
		int   n_before;
		logic stop_seen;
		n_before = word_expect_q.size();
		if (token_open) begin
			lead_dash  = (c == CH_HYPHEN);
			token_open = 1'b0;
		end
		if (c != CH_DQUOTE) begin
			last_plain = c;
			have_plain = 1'b1;
		end
		if (is_word_char(c)) begin
			// a letter or digit confirms every held mark
			if (word_seen)
				foreach (held_q[i])
					push_word_result(held_q[i], 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
			held_q.delete();
			word_seen = 1'b1;
			push_word_result((c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c,
				1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		end else if ((c == CH_APOS || c == CH_HYPHEN) && word_seen) begin
			if (held_q.size() < STORE_DEPTH)
				held_q.push_back(c);
			else
				marks_lost = 1'b1;
		end
		if (fin) begin
			stop_seen = have_plain && (last_plain == CH_PERIOD || last_plain == CH_BANG ||
				last_plain == CH_QMARK || last_plain == CH_COLON);
			push_word_result(8'h00, 1'b1, stop_seen, lead_dash, !word_seen, marks_lost);
			word_seen  = 1'b0;
			held_q.delete();
			last_plain = 8'h00;
			have_plain = 1'b0;
			token_open = 1'b1;
			lead_dash  = 1'b0;
			marks_lost = 1'b0;
		end
		if (word_expect_q.size() > n_before)
			word_expect_q[word_expect_q.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %h want %h",
				results_seen, name, got, want));
	endtask

	task automatic check_word_result();
		wtn_res_t want;
		if (word_expect_q.size() == 0) begin
			report_mismatch($sformatf("result %0d unexpected: char %h term %b",
				results_seen, word.out_char, word.is_terminator));
		end else begin
			want = word_expect_q.pop_front();
			check_field("out_char", word.out_char, want.ch);
			check_field("is_terminator", word.is_terminator, want.term);
			check_field("sentence_end", word.sentence_end, want.se);
			check_field("dialogue_start", word.dialogue_start, want.ds);
			check_field("word_empty", word.word_empty, want.we);
			check_field("pending_overflow", word.pending_overflow, want.po);
			check_field("last_result", word.last_result, want.last);
		end
		results_seen++;
	endtask

	// monitor: predict on input transfers, check output transfers, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (tok.valid === 1'b1 && tok.ready === 1'b1)
				predict_clean_byte(tok.char_code, tok.last_in_token);
			if (word.valid === 1'b1 && word.ready === 1'b1)
				check_word_result();
			if ((tok.valid === 1'b1 && tok.ready === 1'b1) ||
			    (word.valid === 1'b1 && word.ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			word.ready <= 1'b0;
			hold_left--;
		end else begin
			word.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// offers one byte, returns at the falling edge after its transfer
	task automatic send_byte(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < tx_idle_pct) begin
			tok.valid <= 1'b0;
			@(negedge clk);
		end
		tok.valid         <= 1'b1;
		tok.char_code     <= c;
		tok.last_in_token <= fin;
		@(posedge clk);
		while (tok.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_token(input byte_q_t t);
		foreach (t[i])
			send_byte(t[i], i == t.size() - 1);
	endtask

	function automatic logic [7:0] pick_alnum();
		case ($urandom_range(0, 2))
			0:       return CH_UPPER_A + 8'($urandom_range(0, 25));
			1:       return CH_LOWER_A + 8'($urandom_range(0, 25));
			default: return CH_DIGIT_0 + 8'($urandom_range(0, 9));
		endcase
	endfunction

	function automatic logic [7:0] pick_mark();
		return $urandom_range(0, 1) ? CH_APOS : CH_HYPHEN;
	endfunction

	function automatic logic [7:0] pick_punct();
		case ($urandom_range(0, 6))
			0:       return CH_PERIOD;
			1:       return CH_BANG;
			2:       return CH_QMARK;
			3:       return CH_COLON;
			4:       return CH_DQUOTE;
			5:       return pick_mark();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// leading punctuation, word segments joined by marks or junk, trailing punctuation
	function automatic byte_q_t make_word_token();
		byte_q_t t;
		int      segs;
		segs = $urandom_range(1, 4);
		repeat ($urandom_range(0, 2))
			t.push_back(pick_punct());
		for (int s = 0; s < segs; s++) begin
			repeat ($urandom_range(1, 4))
				t.push_back(pick_alnum());
			if (s < segs - 1)
				repeat ($urandom_range(1, 3))
					t.push_back(($urandom_range(99) < 70) ? pick_mark() :
						8'($urandom_range(0, 255)));
		end
		repeat ($urandom_range(0, 3))
			t.push_back(pick_punct());
		return t;
	endfunction

	function automatic byte_q_t make_noise_token();
		byte_q_t t;
		repeat ($urandom_range(1, 5))
			t.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_punct());
		return t;
	endfunction

	// extremes of the byte range, alnum boundaries, quotes, leading and trailing marks
	task automatic test_directed();
		byte_q_t t;
		tx_idle_pct  = 35;
		rx_stall_pct = 81;
		// zero byte as a single-byte token: empty word
		t = '{8'h00};
		send_token(t);
		// dialogue dash, range edges around digits and letters, held marks
		// flushed by a later letter, stop before a closing quote
		t = '{CH_HYPHEN, 8'h2F, CH_DIGIT_0, CH_DIGIT_9, CH_COLON, 8'h40, CH_UPPER_A,
			CH_UPPER_Z, 8'h5B, 8'h60, CH_LOWER_Z, 8'h7B, 8'hFF, CH_APOS, CH_HYPHEN,
			8'h6B, CH_PERIOD, CH_DQUOTE};
		send_token(t);
		// only double quotes: no sentence end
		t = '{CH_DQUOTE, CH_DQUOTE};
		send_token(t);
		// leading mark dropped, trailing mark discarded
		t = '{CH_APOS, 8'h78, CH_HYPHEN, CH_BANG};
		send_token(t);
	endtask

	// full mark store with the output held off, so the core backs up
	task automatic test_store_full();
		byte_q_t t;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		tok.valid <= 1'b0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		// overflow inside the word, then a full flush on the final byte
		t.push_back(8'h77);
		for (int i = 0; i < STORE_DEPTH + 1; i++)
			t.push_back(i % 2 ? CH_APOS : CH_HYPHEN);
		t.push_back(8'h79);
		send_token(t);
		// overflow caused only by trailing marks
		t.delete();
		t.push_back(8'h56);
		repeat (STORE_DEPTH + 1)
			t.push_back(CH_APOS);
		send_token(t);
	endtask

	task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
		int stop_at;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 80)
				send_token(make_word_token());
			else
				send_token(make_noise_token());
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		tok.valid          = 1'b0;
		tok.char_code      = 8'h00;
		tok.last_in_token  = 1'b0;
		word.ready         = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_store_full();
		test_random_phase(35, 81, 10);
		test_random_phase(81, 35, 10);
		test_random_phase(0, 0, 10);

		tok.valid <= 1'b0;
		while (word_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (word_expect_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", word_expect_q.size()));
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/wtn_pkg.sv
sv/wtn_tok_if.sv
sv/wtn_word_if.sv
sv/wtn_front.sv
sv/wtn_fifo.sv
sv/wtn_back.sv
sv/word_token_normalizer_core.sv
tb/word_token_normalizer_core_tb.sv
